// ===== rtl/pwc_pkg.sv =====
// Shared types, constants and register codes of the PID controller with clamps.
`timescale 1ns / 1ps

package pwc_pkg;

   // Fixed field widths.
   localparam int VALUE_W   = 32;             // setpoint and measurement
   localparam int ERR_W     = VALUE_W + 1;    // exact error
   localparam int DIFF_W    = ERR_W + 1;      // error difference
   localparam int SUM_W     = 40;             // accumulated error
   localparam int GAIN_W    = 24;
   localparam int ILIM_W    = 39;
   localparam int OLIM_W    = 15;
   localparam int DRIVE_W   = 16;

   // Product and sum widths in the back part.
   localparam int P_W       = GAIN_W + 1 + ERR_W;    // 58
   localparam int D_W       = GAIN_W + 1 + DIFF_W;   // 59
   localparam int IPROD_W   = GAIN_W + 1 + SUM_W;    // 65
   localparam int PD_W      = D_W + 1;               // 60
   localparam int TOT_W     = 62;

   // The integral product is held within +-2^60 before the sum.
   localparam int IPROD_CAP_BIT = 60;
   localparam logic signed [IPROD_W-1:0] IPROD_CAP =
      {{(IPROD_W-IPROD_CAP_BIT-1){1'b0}}, 1'b1, {IPROD_CAP_BIT{1'b0}}};

   // Angle mode quantizer: divide by 50 through a reciprocal multiply.
   localparam int          QUANT_STEP  = 50;
   localparam int          QUANT_SHIFT = 37;
   localparam logic [31:0] QUANT_RECIP = 32'd2748779069;  // floor(2^37 / 50)
   localparam int          QPROD_W     = ERR_W + 32;
   localparam int          QUO_W       = QPROD_W - QUANT_SHIFT;

   // Defaults for the top level parameters.
   localparam int GAIN_FRAC_BITS_DEFAULT = 12;
   localparam int WORK_DEPTH_DEFAULT     = 4;
   localparam int RSP_DEPTH_DEFAULT      = 4;

   // Register port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = ILIM_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_P         = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_I         = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_D         = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_INTEGRAL_LIMIT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUTPUT_LIMIT   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ANGLE_MODE     = 3'd5;

   localparam logic [ILIM_W-1:0] INTEGRAL_LIMIT_RESET = {ILIM_W{1'b1}};
   localparam logic [OLIM_W-1:0] OUTPUT_LIMIT_RESET   = 15'd16000;

   typedef struct packed {
      logic                      enable;
      logic signed [VALUE_W-1:0] setpoint;
      logic signed [VALUE_W-1:0] measured;
   } req_type;

   typedef struct packed {
      logic signed [DRIVE_W-1:0] drive;
      logic                      clamped;
   } rsp_type;

   typedef struct packed {
      logic [GAIN_W-1:0] gain_p;
      logic [GAIN_W-1:0] gain_i;
      logic [GAIN_W-1:0] gain_d;
      logic [ILIM_W-1:0] integral_limit;
      logic [OLIM_W-1:0] output_limit;
      logic              angle_mode;
   } cfg_type;

   // One step's work as handed from the front part to the back part.
   typedef struct packed {
      logic                     enable;
      logic signed [ERR_W-1:0]  err;
      logic signed [SUM_W-1:0]  err_sum;
      logic signed [DIFF_W-1:0] err_diff;
   } work_type;

endpackage

// ===== rtl/pwc_fifo.sv =====
// Small first-in first-out queue built from registers.
`timescale 1ns / 1ps

module pwc_fifo #(
   parameter type item_type = logic,
   parameter int  DEPTH     = 4
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_data,
   output logic     full,
   input  logic     pop,
   output item_type pop_data,
   output logic     empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   item_type        mem_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/pwc_front.sv =====
// Front part: takes items, forms the error and updates the integral and last error.
`timescale 1ns / 1ps

module pwc_front import pwc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  req_type  req_data,
   output logic     full,
   input  cfg_type  cfg,
   output logic     work_push,
   output work_type work_data,
   input  logic     work_full
);

   logic                     adv;
   logic [4:0]               valid_ff, valid_in;

   // Stage 1: raw error.
   logic                     s1_en_ff, s1_en_in;
   logic signed [ERR_W-1:0]  s1_err_ff, s1_err_in;

   // Stage 2: sign and magnitude.
   logic                     s2_en_ff;
   logic signed [ERR_W-1:0]  s2_err_ff;
   logic                     s2_neg_ff, s2_neg_in;
   logic [ERR_W-1:0]         s2_mag_ff, s2_mag_in;

   // Stage 3: quotient estimate by 50.
   logic                     s3_en_ff;
   logic signed [ERR_W-1:0]  s3_err_ff;
   logic                     s3_neg_ff;
   logic [ERR_W-1:0]         s3_mag_ff;
   logic [QUO_W-1:0]         s3_quo_ff, s3_quo_in;
   logic [QPROD_W-1:0]       quo_prod;

   // Stage 4: multiple of 50 and whether the estimate was one short.
   logic                     s4_en_ff;
   logic signed [ERR_W-1:0]  s4_err_ff;
   logic                     s4_neg_ff;
   logic [ERR_W-1:0]         s4_base_ff, s4_base_in;
   logic                     s4_bump_ff, s4_bump_in;
   logic [ERR_W:0]           mul50, rem;

   // Stage 5: final error.
   logic                     s5_en_ff;
   logic signed [ERR_W-1:0]  s5_err_ff, s5_err_in;
   logic [ERR_W-1:0]         fixed_mag;
   logic signed [ERR_W-1:0]  quant_err;

   // Loop state.
   logic signed [SUM_W-1:0]  err_sum_ff, err_sum_in;
   logic signed [ERR_W-1:0]  prev_err_ff, prev_err_in;
   logic signed [SUM_W:0]    sum_wide, lim_pos, lim_neg;
   logic signed [SUM_W-1:0]  sum_clamped;
   logic signed [DIFF_W-1:0] diff;

   // The whole front moves unless its last stage is blocked by a full queue.
   assign adv  = !(valid_ff[4] && work_full);
   assign full = !adv;

   always_comb begin
      valid_in  = adv ? {valid_ff[3:0], push} : valid_ff;

      s1_en_in  = req_data.enable;
      s1_err_in = $signed({req_data.setpoint[VALUE_W-1], req_data.setpoint})
                - $signed({req_data.measured[VALUE_W-1], req_data.measured});

      s2_neg_in = s1_err_ff[ERR_W-1];
      s2_mag_in = s1_err_ff[ERR_W-1] ? ERR_W'(-s1_err_ff) : ERR_W'(s1_err_ff);

      quo_prod  = QPROD_W'(s2_mag_ff) * QPROD_W'(QUANT_RECIP);
      s3_quo_in = quo_prod[QPROD_W-1:QUANT_SHIFT];

      mul50      = (ERR_W+1)'(s3_quo_ff) * (ERR_W+1)'(QUANT_STEP);
      rem        = (ERR_W+1)'(s3_mag_ff) - mul50;
      s4_base_in = mul50[ERR_W-1:0];
      s4_bump_in = (rem >= (ERR_W+1)'(QUANT_STEP));

      fixed_mag  = s4_base_ff + (s4_bump_ff ? ERR_W'(QUANT_STEP) : '0);
      quant_err  = s4_neg_ff ? -$signed(fixed_mag) : $signed(fixed_mag);
      s5_err_in  = cfg.angle_mode ? quant_err : s4_err_ff;
   end

   // Integral update and error difference for the item leaving the front.
   always_comb begin
      sum_wide = $signed({err_sum_ff[SUM_W-1], err_sum_ff})
               + $signed({{(SUM_W-ERR_W+1){s5_err_ff[ERR_W-1]}}, s5_err_ff});
      lim_pos  = $signed({2'b00, cfg.integral_limit});
      lim_neg  = -lim_pos;
      if (sum_wide > lim_pos) begin
         sum_clamped = lim_pos[SUM_W-1:0];
      end else if (sum_wide < lim_neg) begin
         sum_clamped = lim_neg[SUM_W-1:0];
      end else begin
         sum_clamped = sum_wide[SUM_W-1:0];
      end
      diff = $signed({s5_err_ff[ERR_W-1], s5_err_ff})
           - $signed({prev_err_ff[ERR_W-1], prev_err_ff});

      work_push          = valid_ff[4] && !work_full;
      work_data.enable   = s5_en_ff;
      work_data.err      = s5_err_ff;
      work_data.err_sum  = sum_clamped;
      work_data.err_diff = diff;

      err_sum_in  = err_sum_ff;
      prev_err_in = prev_err_ff;
      if (work_push) begin
         if (s5_en_ff) begin
            err_sum_in  = sum_clamped;
            prev_err_in = s5_err_ff;
         end else begin
            err_sum_in  = '0;
            prev_err_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         err_sum_ff  <= '0;
         prev_err_ff <= '0;
      end else begin
         valid_ff    <= valid_in;
         err_sum_ff  <= err_sum_in;
         prev_err_ff <= prev_err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_en_ff   <= s1_en_in;
         s1_err_ff  <= s1_err_in;
         s2_en_ff   <= s1_en_ff;
         s2_err_ff  <= s1_err_ff;
         s2_neg_ff  <= s2_neg_in;
         s2_mag_ff  <= s2_mag_in;
         s3_en_ff   <= s2_en_ff;
         s3_err_ff  <= s2_err_ff;
         s3_neg_ff  <= s2_neg_ff;
         s3_mag_ff  <= s2_mag_ff;
         s3_quo_ff  <= s3_quo_in;
         s4_en_ff   <= s3_en_ff;
         s4_err_ff  <= s3_err_ff;
         s4_neg_ff  <= s3_neg_ff;
         s4_base_ff <= s4_base_in;
         s4_bump_ff <= s4_bump_in;
         s5_en_ff   <= s4_en_ff;
         s5_err_ff  <= s5_err_in;
      end
   end

endmodule

// ===== rtl/pwc_back.sv =====
// Back part: gain products, integral product cap, sum, fixed point shift and output clamp.
`timescale 1ns / 1ps

module pwc_back import pwc_pkg::*; #(
   parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     work_empty,
   input  work_type work_data,
   output logic     work_pop,
   output logic     rsp_push,
   output rsp_type  rsp_item,
   input  logic     rsp_full
);

   logic                      adv;
   logic [3:0]                valid_ff, valid_in;

   logic                      b1_en_ff;
   logic signed [P_W-1:0]     b1_p_ff, b1_p_in;
   logic signed [IPROD_W-1:0] b1_i_ff, b1_i_in;
   logic signed [D_W-1:0]     b1_d_ff, b1_d_in;

   logic                      b2_en_ff;
   logic signed [TOT_W-1:0]   b2_isat_ff, b2_isat_in;
   logic signed [PD_W-1:0]    b2_pd_ff, b2_pd_in;

   logic                      b3_en_ff;
   logic signed [TOT_W-1:0]   b3_total_ff, b3_total_in;

   rsp_type                   b4_rsp_ff, b4_rsp_in;
   logic signed [TOT_W-1:0]   shifted, olim_pos, olim_neg;

   assign adv      = !(valid_ff[3] && rsp_full);
   assign work_pop = adv && !work_empty;
   assign rsp_push = valid_ff[3] && !rsp_full;
   assign rsp_item = b4_rsp_ff;

   always_comb begin
      valid_in = adv ? {valid_ff[2:0], !work_empty} : valid_ff;

      b1_p_in = P_W'($signed({1'b0, cfg.gain_p})) * P_W'(work_data.err);
      b1_i_in = IPROD_W'($signed({1'b0, cfg.gain_i})) * IPROD_W'(work_data.err_sum);
      b1_d_in = D_W'($signed({1'b0, cfg.gain_d})) * D_W'(work_data.err_diff);

      if (b1_i_ff > IPROD_CAP) begin
         b2_isat_in = IPROD_CAP[TOT_W-1:0];
      end else if (b1_i_ff < -IPROD_CAP) begin
         b2_isat_in = TOT_W'(-IPROD_CAP);
      end else begin
         b2_isat_in = b1_i_ff[TOT_W-1:0];
      end
      b2_pd_in = PD_W'(b1_p_ff) + PD_W'(b1_d_ff);

      b3_total_in = TOT_W'(b2_pd_ff) + b2_isat_ff;

      shifted  = b3_total_ff >>> GAIN_FRAC_BITS;
      olim_pos = $signed(TOT_W'(cfg.output_limit));
      olim_neg = -olim_pos;
      if (!b3_en_ff) begin
         b4_rsp_in.drive   = '0;
         b4_rsp_in.clamped = 1'b0;
      end else if (shifted > olim_pos) begin
         b4_rsp_in.drive   = olim_pos[DRIVE_W-1:0];
         b4_rsp_in.clamped = 1'b1;
      end else if (shifted < olim_neg) begin
         b4_rsp_in.drive   = olim_neg[DRIVE_W-1:0];
         b4_rsp_in.clamped = 1'b1;
      end else begin
         b4_rsp_in.drive   = shifted[DRIVE_W-1:0];
         b4_rsp_in.clamped = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b1_en_ff    <= work_data.enable;
         b1_p_ff     <= b1_p_in;
         b1_i_ff     <= b1_i_in;
         b1_d_ff     <= b1_d_in;
         b2_en_ff    <= b1_en_ff;
         b2_isat_ff  <= b2_isat_in;
         b2_pd_ff    <= b2_pd_in;
         b3_en_ff    <= b2_en_ff;
         b3_total_ff <= b3_total_in;
         b4_rsp_ff   <= b4_rsp_in;
      end
   end

endmodule

// ===== rtl/pid_with_clamps.sv =====
// Top level of the positional PID controller with integral and output clamps.
`timescale 1ns / 1ps

// The block runs one step of a positional PID loop for each item. The input
// channel behaves like a queue: an item (enable, setpoint, measured) is taken
// at a clock edge where push is high and full is low. Results come out of a
// queue as well: the oldest result (drive, clamped) is on rsp_data while
// empty is low, and it is taken at an edge where pop is high.
// Gains and limits are written through the csr_ port, one register per
// write; the user must do so only while no item is in flight, as the block
// does not enforce it. Throughput is one item per clock cycle when nothing
// stalls. An item passes five front stages that form the error (the angle
// mode divide by 50 is a reciprocal multiply with a correction step) and
// update the integral, a work queue, and four back stages that form the
// three gain products, their sum, the shift and clamp, before empty falls.
// When the receiver stops popping, the result queue fills, the back part
// holds, the work queue fills and full rises; no item is lost or repeated.
// Reset clears the integral, the last error and both queues, and puts the
// registers at their reset values (zero gains, the widest integral limit,
// output limit 16000, angle mode off).
module pid_with_clamps import pwc_pkg::*; #(
   parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEFAULT,
   parameter int WORK_DEPTH     = WORK_DEPTH_DEFAULT,
   parameter int RSP_DEPTH      = RSP_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  req_type                req_data,
   output logic                   full,
   output logic                   empty,
   input  logic                   pop,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type  cfg_ff, cfg_in;

   logic     work_push, work_full, work_pop, work_empty;
   work_type work_in_data, work_out_data;

   logic     rsp_push, rsp_full;
   rsp_type  rsp_item;

   // Register writes. Codes outside the list are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_GAIN_P:         cfg_in.gain_p         = csr_wdata[GAIN_W-1:0];
            CSR_GAIN_I:         cfg_in.gain_i         = csr_wdata[GAIN_W-1:0];
            CSR_GAIN_D:         cfg_in.gain_d         = csr_wdata[GAIN_W-1:0];
            CSR_INTEGRAL_LIMIT: cfg_in.integral_limit = csr_wdata[ILIM_W-1:0];
            CSR_OUTPUT_LIMIT:   cfg_in.output_limit   = csr_wdata[OLIM_W-1:0];
            CSR_ANGLE_MODE:     cfg_in.angle_mode     = csr_wdata[0];
            default:            cfg_in                = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p         <= '0;
         cfg_ff.gain_i         <= '0;
         cfg_ff.gain_d         <= '0;
         cfg_ff.integral_limit <= INTEGRAL_LIMIT_RESET;
         cfg_ff.output_limit   <= OUTPUT_LIMIT_RESET;
         cfg_ff.angle_mode     <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front owns the loop state, so items pass through it strictly in order.
   pwc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .req_data  (req_data),
      .full      (full),
      .cfg       (cfg_ff),
      .work_push (work_push),
      .work_data (work_in_data),
      .work_full (work_full)
   );

   pwc_fifo #(
      .item_type (work_type),
      .DEPTH     (WORK_DEPTH)
   ) u_work_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (work_push),
      .push_data (work_in_data),
      .full      (work_full),
      .pop       (work_pop),
      .pop_data  (work_out_data),
      .empty     (work_empty)
   );

   pwc_back #(
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .work_empty (work_empty),
      .work_data  (work_out_data),
      .work_pop   (work_pop),
      .rsp_push   (rsp_push),
      .rsp_item   (rsp_item),
      .rsp_full   (rsp_full)
   );

   // The result queue decouples the back part from a stalling receiver.
   pwc_fifo #(
      .item_type (rsp_type),
      .DEPTH     (RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_item),
      .full      (rsp_full),
      .pop       (pop),
      .pop_data  (rsp_data),
      .empty     (empty)
   );

endmodule
